[rtl/csmd_pkg.sv]
// ----------------------------------------------------------------------------
// csmd_pkg
// Shared constants, types and helpers for the cubic segment minimum
// duration block.
// ----------------------------------------------------------------------------
package csmd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    // wide work register: radicand and products
    localparam int XW        = 72;
    // multiplier / divisor operand width
    localparam int BW        = 36;
    // partial remainder width
    localparam int RW        = 40;
    // dividend width: 36-bit numerator shifted by the fraction
    localparam int DIV_W     = 36 + FRAC_BITS;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 192;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef enum logic [3:0] {
        ST_LIN,
        ST_MULA,
        ST_MUL1,
        ST_SQ1,
        ST_DV1,
        ST_MUL2,
        ST_SQ2,
        ST_DV2,
        ST_FIN
    } step_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ISSUE,
        S_WAIT,
        S_END,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  check;
        logic  start;
        logic  capture;
        step_t step;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
        logic n_neg;
        logic last;
        logic done;
        logic need_div;
        logic out_free;
    } stat_t;

    function automatic logic [DATA_W-1:0] sat32(input logic [XW-1:0] v);
        logic [DATA_W-1:0] r;
        if (|v[XW-1:DATA_W]) begin
            r = '1;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/csmd_iter.sv]
// ----------------------------------------------------------------------------
// csmd_iter
// Shared iterative unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit (or bit pair) per cycle.
// ----------------------------------------------------------------------------
module csmd_iter
    import csmd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  op_t           op,
    input  logic [XW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [XW-1:0] result
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    op_t              op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [XW-1:0]    x_reg, x_next;
    logic [XW-1:0]    y_reg, y_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [RW-1:0]    r_reg, r_next;

    logic [BW:0]      dtrial;
    logic             dge;
    logic [RW-1:0]    srem;
    logic [RW-1:0]    strial;
    logic             sge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        b_next    = b_reg;
        r_next    = r_reg;

        dtrial = {r_reg[BW-1:0], x_reg[DIV_W-1]};
        dge    = dtrial >= {1'b0, b_reg};
        srem   = {r_reg[RW-3:0], x_reg[XW-1:XW-2]};
        strial = {y_reg[RW-3:0], 2'b01};
        sge    = srem >= strial;

        if (start) begin
            busy_next = 1'b1;
            op_next   = op;
            x_next    = a;
            y_next    = '0;
            b_next    = b;
            r_next    = '0;
            case (op)
                OP_MUL:  cnt_next = CNT_W'(BW);
                OP_DIV:  cnt_next = CNT_W'(DIV_W);
                OP_SQRT: cnt_next = CNT_W'(XW / 2);
                default: cnt_next = CNT_W'(BW);
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                OP_MUL: begin
                    if (b_reg[0]) begin
                        y_next = y_reg + x_reg;
                    end
                    x_next = x_reg << 1;
                    b_next = b_reg >> 1;
                end
                OP_DIV: begin
                    r_next = dge ? RW'(dtrial - {1'b0, b_reg}) : RW'(dtrial);
                    y_next = {y_reg[XW-2:0], dge};
                    x_next = x_reg << 1;
                end
                OP_SQRT: begin
                    r_next = sge ? (srem - strial) : srem;
                    y_next = {y_reg[XW-2:0], sge};
                    x_next = x_reg << 2;
                end
                default: begin
                    y_next = y_reg;
                end
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done   = done_reg;
    assign result = y_reg;

endmodule

[rtl/csmd_datapath.sv]
// ----------------------------------------------------------------------------
// csmd_datapath
// Joint registers, operand selection for the shared unit, running rate
// minimum, configuration register and output register.
// ----------------------------------------------------------------------------
module csmd_datapath
    import csmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                st,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_valid,
    input  logic [DATA_W-1:0]    cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,
    output logic                 m_tuser
);

    logic [31:0]        mag_reg;
    logic               dz_reg;
    logic signed [34:0] n_reg;
    logic signed [35:0] c1_reg, c2_reg;
    logic [30:0]        accel_reg;
    logic               last_reg;
    logic [XW-1:0]      pa_reg, x_reg;
    logic [35:0]        s_reg;
    logic [DATA_W-1:0]  fin_q_reg;
    logic [DATA_W-1:0]  rate_min_reg;
    logic               unb_reg, inf_reg;
    logic [DATA_W-1:0]  min_dur_reg;
    logic               m_tvalid_reg;
    logic [DATA_W-1:0]  m_tdata_reg;
    logic               m_tuser_reg;

    // input decode
    logic signed [31:0] sp, sv, ep, ev;
    logic signed [32:0] d_w, sum_w;
    logic               neg_w;
    logic [31:0]        mag_w;
    logic signed [34:0] n_w;
    logic signed [35:0] c1_raw, c2_raw;

    always_comb begin
        sp     = s_tdata[31:0];
        sv     = s_tdata[63:32];
        ep     = s_tdata[95:64];
        ev     = s_tdata[127:96];
        d_w    = {ep[31], ep} - {sp[31], sp};
        neg_w  = d_w[32];
        // travel never exceeds 2^32 - 1
        mag_w  = neg_w ? 32'(-d_w) : 32'(d_w);
        sum_w  = {sv[31], sv} + {ev[31], ev};
        n_w    = $signed({4'b0, s_tdata[189:159]})
               + (neg_w ? -{{2{sum_w[32]}}, sum_w} : {{2{sum_w[32]}}, sum_w});
        c1_raw = ({{4{sv[31]}}, sv} <<< 2) + ({{4{ev[31]}}, ev} <<< 1);
        c2_raw = ({{4{ev[31]}}, ev} <<< 2) + ({{4{sv[31]}}, sv} <<< 1);
    end

    // operand selection
    logic signed [35:0] cq;
    logic [35:0]        cabs;
    logic signed [36:0] numq;
    logic [35:0]        numq_c;
    op_t                op;
    logic [XW-1:0]      opa;
    logic [BW-1:0]      opb;
    logic               done;
    logic [XW-1:0]      result;
    logic [DATA_W-1:0]  res_sat;

    always_comb begin
        cq = (cmd.step == ST_MUL2 || cmd.step == ST_SQ2 || cmd.step == ST_DV2)
           ? c2_reg : c1_reg;
        cabs   = cq[35] ? 36'(-cq) : 36'(cq);
        numq   = {cq[35], cq} + $signed({1'b0, s_reg});
        numq_c = numq[36] ? '0 : numq[35:0];
        case (cmd.step)
            ST_LIN: begin
                op  = OP_DIV;
                opa = XW'(n_reg[33:0]) << FRAC_BITS;
                opb = BW'({mag_reg, 1'b0}) + BW'(mag_reg);
            end
            ST_MULA: begin
                op  = OP_MUL;
                opa = (XW'(mag_reg) << 4) + (XW'(mag_reg) << 3);
                opb = BW'(accel_reg);
            end
            ST_MUL1, ST_MUL2: begin
                op  = OP_MUL;
                opa = XW'(cabs);
                opb = cabs;
            end
            ST_SQ1, ST_SQ2: begin
                op  = OP_SQRT;
                opa = x_reg;
                opb = '0;
            end
            ST_DV1, ST_DV2: begin
                op  = OP_DIV;
                opa = XW'(numq_c) << FRAC_BITS;
                opb = (BW'(mag_reg) << 3) + (BW'(mag_reg) << 2);
            end
            ST_FIN: begin
                op  = OP_DIV;
                opa = (XW'(1) << (2 * FRAC_BITS)) + XW'(rate_min_reg) - XW'(1);
                opb = BW'(rate_min_reg);
            end
            default: begin
                op  = OP_MUL;
                opa = '0;
                opb = '0;
            end
        endcase
    end

    csmd_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .op      (op),
        .a       (opa),
        .b       (opb),
        .done    (done),
        .result  (result)
    );

    assign res_sat = sat32(result);

    logic              fold;
    logic [DATA_W-1:0] dur_w;
    logic              out_free;

    always_comb begin
        fold = cmd.capture
            && (cmd.step == ST_LIN || cmd.step == ST_DV1 || cmd.step == ST_DV2)
            && (unb_reg || res_sat < rate_min_reg);
        if (inf_reg) begin
            dur_w = '0;
        end else if (unb_reg) begin
            dur_w = min_dur_reg;
        end else if (rate_min_reg == '0) begin
            dur_w = '1;
        end else if (fin_q_reg < min_dur_reg) begin
            dur_w = min_dur_reg;
        end else begin
            dur_w = fin_q_reg;
        end
        out_free = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_min_reg <= '1;
            unb_reg      <= 1'b1;
            inf_reg      <= 1'b0;
            min_dur_reg  <= DATA_W'(1) << FRAC_BITS;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                min_dur_reg <= cfg_data;
            end
            if (cmd.out_load) begin
                rate_min_reg <= '1;
                unb_reg      <= 1'b1;
                inf_reg      <= 1'b0;
            end else begin
                if (fold) begin
                    rate_min_reg <= res_sat;
                    unb_reg      <= 1'b0;
                end
                if (cmd.check && !dz_reg && n_reg[34]) begin
                    inf_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg   <= mag_w;
            dz_reg    <= (d_w == '0);
            n_reg     <= n_w;
            c1_reg    <= neg_w ? -c1_raw : c1_raw;
            c2_reg    <= neg_w ? -c2_raw : c2_raw;
            accel_reg <= s_tdata[158:128];
            last_reg  <= s_tlast;
        end
        if (cmd.capture) begin
            case (cmd.step)
                ST_MULA:          pa_reg    <= result;
                ST_MUL1, ST_MUL2: x_reg     <= pa_reg + result;
                ST_SQ1, ST_SQ2:   s_reg     <= result[35:0];
                ST_FIN:           fin_q_reg <= res_sat;
                default:          s_reg     <= s_reg;
            endcase
        end
        if (cmd.out_load) begin
            m_tdata_reg <= dur_w;
            m_tuser_reg <= !inf_reg;
        end
    end

    always_comb begin
        st.d_zero   = dz_reg;
        st.n_neg    = n_reg[34];
        st.last     = last_reg;
        st.done     = done;
        st.need_div = !inf_reg && !unb_reg && (rate_min_reg != '0);
        st.out_free = out_free;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/csmd_ctrl.sv]
// ----------------------------------------------------------------------------
// csmd_ctrl
// Sequencer: steps one joint through the linear bound and both quadratic
// bounds on the shared unit, then the final reciprocal on the last joint if needed.
// ----------------------------------------------------------------------------
module csmd_ctrl
    import csmd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= ST_LIN;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (st.d_zero || st.n_neg) begin
                    state_next = S_END;
                end else begin
                    step_next  = ST_LIN;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (st.done) begin
                    cmd.capture = 1'b1;
                    state_next  = S_ISSUE;
                    case (step_reg)
                        ST_LIN:  step_next = ST_MULA;
                        ST_MULA: step_next = ST_MUL1;
                        ST_MUL1: step_next = ST_SQ1;
                        ST_SQ1:  step_next = ST_DV1;
                        ST_DV1:  step_next = ST_MUL2;
                        ST_MUL2: step_next = ST_SQ2;
                        ST_SQ2:  step_next = ST_DV2;
                        ST_DV2:  state_next = S_END;
                        ST_FIN:  state_next = S_RESULT;
                        default: state_next = S_END;
                    endcase
                end
            end
            S_END: begin
                if (!st.last) begin
                    state_next = S_IDLE;
                end else if (st.need_div) begin
                    step_next  = ST_FIN;
                    state_next = S_ISSUE;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the unit cannot report completion right after it was started
    a_no_early_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !st.done)
        else $error("shared unit done right after start");

    // completion only arrives while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        st.done |-> state_reg == S_WAIT)
        else $error("unit done outside wait");

    // a result is never loaded over one not yet taken
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("output word overwritten");

    // a new word is only taken when no joint is in flight
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_CHECK && !st.done)
        else $error("word taken while busy");

endmodule

[rtl/cubic_segment_minimum_duration.sv]
// ----------------------------------------------------------------------------
// cubic_segment_minimum_duration
// Minimum duration of a cubic segment from per-joint velocity and
// acceleration limits, with a running rate minimum over the joints.
// ----------------------------------------------------------------------------
// A feasible joint word with nonzero travel runs three divides of 52 steps,
// three multiplies of 36 steps and two square roots of 36 steps on one
// shared bit-serial unit, each started from an issue state and captured on done.
// A joint with no travel skips the shared unit. The last joint adds a 52-step
// reciprocal divide when needed; the result sits in an output register so
// the next word can be taken while it waits. Synchronous active-low reset
// clears the running minimum and sets minimum_duration to 1.0.
module cubic_segment_minimum_duration
    import csmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // start_pos, start_vel, end_pos, end_vel, accel_limit, vel_limit, pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // duration
    output logic [DATA_W-1:0]    m_tdata,
    // feasible
    output logic                 m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DATA_W-1:0]    cfg_data
);

    cmd_t  cmd;
    stat_t st;

    csmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    csmd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    assign cfg_ready = 1'b1;

endmodule
